// ===== design/bwms_pkg.sv =====
// Shared types, constants and helpers for the bucketed window mean block.
package bwms_pkg;

  localparam int SPAN_W      = 48;
  localparam int DT_W        = 32;
  localparam int MEAN_W      = 32;
  localparam int BC_W        = 5;
  localparam int FAC_W       = 24;
  localparam int START_W     = 32;
  localparam int SEED_W      = 36;
  localparam int BIN_TIME_W  = 48;
  localparam int BIN_STEPS_W = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CNT_W       = 5;
  localparam int MUL_STEPS   = FAC_W;
  localparam int DIV_STEPS   = MEAN_W;

  typedef struct packed {
    logic [SPAN_W-1:0] bin_span;
    logic [DT_W-1:0]   step_dt;
  } in_word_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_dt;
    logic              no_estimate;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_COUNT = 2'd0,
    CFG_DT_FACTOR = 2'd1,
    CFG_START_DT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_UPD,
    ST_CLR,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_EMIT
  } state_t;

  // 10 * v as 8v + 2v
  function automatic logic [SEED_W-1:0] ten_times(input logic [START_W-1:0] v);
    return {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
  endfunction

endpackage

// ===== design/bucketed_window_mean_step_top.sv =====
// Bucketed sliding-window mean of step durations: bin store, running totals, serial mean unit.
// Sequence: an accepted word passes the add and update states, a bin clear when the current
//   bin closes, then the 24-step shift-add multiplier and the 32-step restoring divider before
//   out_valid rises; with no bins in use the result is loaded straight from the emit state.
// Throughput: a new word is taken only once the last result has been loaded; a finished result
//   waits in the output register while the next word is taken.
// Reset: rst_n synchronous, active low; registers return to bin_count 8, gain 1.0 and start
//   duration 1.0, and per-bin valid flags make the store read as freshly seeded at once.
module bucketed_window_mean_step_top #(
  parameter int MAX_BINS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bwms_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bwms_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bwms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bwms_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int BW  = $clog2(MAX_BINS);
  localparam int NW  = ($clog2(MAX_BINS + 1) > bwms_pkg::BC_W) ?
                       $clog2(MAX_BINS + 1) : bwms_pkg::BC_W;
  localparam int TW  = bwms_pkg::BIN_TIME_W + BW;
  localparam int SW  = bwms_pkg::BIN_STEPS_W + BW;
  localparam int PW  = TW + bwms_pkg::FAC_W;
  localparam int QW  = PW - bwms_pkg::FRAC_W;
  localparam int HTW = bwms_pkg::BIN_TIME_W;
  localparam int HSW = bwms_pkg::BIN_STEPS_W;

  // configuration
  logic [bwms_pkg::BC_W-1:0]     bin_count_r, bin_count_nxt;
  logic [bwms_pkg::FAC_W-1:0]    dt_factor_r, dt_factor_nxt;
  logic [bwms_pkg::START_W-1:0]  start_dt_r, start_dt_nxt;

  bwms_pkg::state_t              state_r, state_nxt;

  logic [IW-1:0]                 cur_bin_r, cur_bin_nxt;
  logic [TW-1:0]                 total_time_r, total_time_nxt;
  logic [SW-1:0]                 total_steps_r, total_steps_nxt;
  logic [bwms_pkg::SPAN_W-1:0]   span_r, span_nxt;
  logic [bwms_pkg::DT_W-1:0]     dt_r, dt_nxt;
  logic [HTW-1:0]                new_time_r, new_time_nxt;
  logic [HSW-1:0]                new_steps_r, new_steps_nxt;
  logic [bwms_pkg::DT_W-1:0]     delta_r, delta_nxt;
  logic                          inc_r, inc_nxt;
  logic [MAX_BINS-1:0]           vld_r, vld_nxt;

  // bin store
  logic [HTW-1:0]                bin_time_mem  [MAX_BINS];
  logic [HSW-1:0]                bin_steps_mem [MAX_BINS];
  logic [HTW-1:0]                rd_time_r;
  logic [HSW-1:0]                rd_steps_r;
  logic                          rd_vld_r;
  logic [IW-1:0]                 rd_bin_r;
  logic [IW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [IW-1:0]                 mem_wa;
  logic [HTW-1:0]                mem_wtime;
  logic [HSW-1:0]                mem_wsteps;

  // serial mean unit
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [bwms_pkg::FAC_W-1:0]    mplr_r, mplr_nxt;
  logic [bwms_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SW-1:0]                 rem_r, rem_nxt;
  logic [bwms_pkg::MEAN_W-1:0]   dvd_r, dvd_nxt;
  logic [bwms_pkg::MEAN_W-1:0]   quo_r, quo_nxt;
  logic                          sat_r, sat_nxt;

  logic                          out_valid_r, out_valid_nxt;
  bwms_pkg::out_word_t           out_data_r, out_data_nxt;

  // combinational helpers
  logic                          in_acc;
  logic                          cfg_we;
  logic                          out_free;
  logic                          load_out;
  logic                          span_hit;
  logic                          mul_last;
  logic                          div_last;
  logic [bwms_pkg::SEED_W-1:0]   seed;
  logic [NW-1:0]                 bins_used;
  logic [NW-1:0]                 cur_plus;
  logic [IW-1:0]                 nxt_bin;
  logic [HTW-1:0]                eff_time;
  logic [HSW-1:0]                eff_steps;
  logic [HTW:0]                  add_sum;
  logic [HTW-1:0]                sat_time;
  logic                          step_inc;
  logic [HTW-1:0]                clr_time;
  logic [HSW-1:0]                clr_steps;
  logic [TW:0]                   mul_sum;
  logic [QW-1:0]                 quot_src;
  logic [SW:0]                   trial;
  logic                          trial_ge;
  logic                          no_est;
  bwms_pkg::out_word_t           result;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign mul_last  = (cnt_r == bwms_pkg::CNT_W'(bwms_pkg::MUL_STEPS - 1));
  assign div_last  = (cnt_r == bwms_pkg::CNT_W'(bwms_pkg::DIV_STEPS - 1));
  assign seed      = bwms_pkg::ten_times(start_dt_r);
  assign bins_used = (NW'(bin_count_r) > NW'(MAX_BINS)) ? NW'(MAX_BINS) : NW'(bin_count_r);
  assign cur_plus  = NW'(cur_bin_r) + NW'(1);
  assign nxt_bin   = (cur_plus >= bins_used) ? '0 : cur_plus[IW-1:0];
  assign span_hit  = (new_time_r > span_r);

  // a bin never written reads as its seeded value
  always_comb begin
    if (rd_vld_r) begin
      eff_time  = rd_time_r;
      eff_steps = rd_steps_r;
    end else if (rd_bin_r == '0) begin
      eff_time  = HTW'(seed);
      eff_steps = HSW'(1);
    end else begin
      eff_time  = '0;
      eff_steps = '0;
    end
  end

  assign add_sum   = {1'b0, eff_time} + (HTW + 1)'(dt_r);
  assign sat_time  = add_sum[HTW] ? '1 : add_sum[HTW-1:0];
  assign step_inc  = (eff_steps != '1);

  // with a single bin the bin to clear is the one just written
  assign clr_time  = (nxt_bin == cur_bin_r) ? new_time_r  : eff_time;
  assign clr_steps = (nxt_bin == cur_bin_r) ? new_steps_r : eff_steps;

  assign mul_sum   = {1'b0, prod_r[PW-1:bwms_pkg::FAC_W]} +
                     (mplr_r[0] ? {1'b0, total_time_r} : '0);
  assign quot_src  = prod_r[PW-1:bwms_pkg::FRAC_W];
  assign trial     = {rem_r, dvd_r[bwms_pkg::MEAN_W-1]};
  assign trial_ge  = (trial >= {1'b0, total_steps_r});

  assign no_est = (bins_used == '0) || (dt_factor_r == '0);
  always_comb begin
    result.no_estimate = no_est;
    result.mean_dt     = (no_est || (total_steps_r == '0) || sat_r) ? '1 : quo_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwms_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (bins_used == '0) ? bwms_pkg::ST_EMIT : bwms_pkg::ST_ADD;
        end
      end
      bwms_pkg::ST_ADD:  state_nxt = bwms_pkg::ST_UPD;
      bwms_pkg::ST_UPD:  state_nxt = span_hit ? bwms_pkg::ST_CLR : bwms_pkg::ST_MUL;
      bwms_pkg::ST_CLR:  state_nxt = bwms_pkg::ST_MUL;
      bwms_pkg::ST_MUL: begin
        if (mul_last) begin
          state_nxt = bwms_pkg::ST_DSET;
        end
      end
      bwms_pkg::ST_DSET: state_nxt = bwms_pkg::ST_DIV;
      bwms_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = bwms_pkg::ST_EMIT;
        end
      end
      bwms_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = bwms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bwms_pkg::ST_IDLE;
    endcase
  end

  // state outputs: handshake and store port control
  always_comb begin
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    load_out   = 1'b0;
    rd_addr    = cur_bin_r;
    mem_we     = 1'b0;
    mem_wa     = cur_bin_r;
    mem_wtime  = new_time_r;
    mem_wsteps = new_steps_r;
    unique case (state_r)
      bwms_pkg::ST_IDLE: begin
        // hold the input while a register write is offered
        in_stall  = cfg_valid;
        cfg_ready = 1'b1;
      end
      bwms_pkg::ST_UPD: begin
        mem_we  = 1'b1;
        rd_addr = nxt_bin;
      end
      bwms_pkg::ST_CLR: begin
        mem_we     = 1'b1;
        mem_wa     = nxt_bin;
        mem_wtime  = '0;
        mem_wsteps = '0;
      end
      bwms_pkg::ST_EMIT: load_out = out_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    bin_count_nxt   = bin_count_r;
    dt_factor_nxt   = dt_factor_r;
    start_dt_nxt    = start_dt_r;
    cur_bin_nxt     = cur_bin_r;
    total_time_nxt  = total_time_r;
    total_steps_nxt = total_steps_r;
    span_nxt        = span_r;
    dt_nxt          = dt_r;
    new_time_nxt    = new_time_r;
    new_steps_nxt   = new_steps_r;
    delta_nxt       = delta_r;
    inc_nxt         = inc_r;
    vld_nxt         = vld_r;
    prod_nxt        = prod_r;
    mplr_nxt        = mplr_r;
    cnt_nxt         = cnt_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    quo_nxt         = quo_r;
    sat_nxt         = sat_r;

    if (mem_we) begin
      vld_nxt[mem_wa] = 1'b1;
    end

    case (state_r)
      bwms_pkg::ST_IDLE: begin
        if (in_acc) begin
          span_nxt = in_data.bin_span;
          dt_nxt   = in_data.step_dt;
        end
      end
      bwms_pkg::ST_ADD: begin
        new_time_nxt  = sat_time;
        new_steps_nxt = eff_steps + HSW'(step_inc);
        delta_nxt     = bwms_pkg::DT_W'(sat_time - eff_time);
        inc_nxt       = step_inc;
      end
      bwms_pkg::ST_UPD: begin
        total_time_nxt  = total_time_r + TW'(delta_r);
        total_steps_nxt = total_steps_r + SW'(inc_r);
        prod_nxt        = '0;
        mplr_nxt        = dt_factor_r;
        cnt_nxt         = '0;
      end
      bwms_pkg::ST_CLR: begin
        total_time_nxt  = total_time_r - TW'(clr_time);
        total_steps_nxt = total_steps_r - SW'(clr_steps);
        cur_bin_nxt     = nxt_bin;
      end
      bwms_pkg::ST_MUL: begin
        prod_nxt = {mul_sum, prod_r[bwms_pkg::FAC_W-1:1]};
        mplr_nxt = mplr_r >> 1;
        cnt_nxt  = cnt_r + bwms_pkg::CNT_W'(1);
      end
      bwms_pkg::ST_DSET: begin
        // a quotient of 2^32 or more saturates
        sat_nxt = (SW'(quot_src[QW-1:bwms_pkg::MEAN_W]) >= total_steps_r);
        rem_nxt = SW'(quot_src[QW-1:bwms_pkg::MEAN_W]);
        dvd_nxt = quot_src[bwms_pkg::MEAN_W-1:0];
        quo_nxt = '0;
        cnt_nxt = '0;
      end
      bwms_pkg::ST_DIV: begin
        rem_nxt = trial_ge ? SW'(trial - {1'b0, total_steps_r}) : trial[SW-1:0];
        dvd_nxt = dvd_r << 1;
        quo_nxt = {quo_r[bwms_pkg::MEAN_W-2:0], trial_ge};
        cnt_nxt = cnt_r + bwms_pkg::CNT_W'(1);
      end
      default: ;
    endcase

    // the multiplier starts from zero after a bin clear too
    if (state_r == bwms_pkg::ST_CLR) begin
      prod_nxt = '0;
      mplr_nxt = dt_factor_r;
      cnt_nxt  = '0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        bwms_pkg::CFG_BIN_COUNT,
        bwms_pkg::CFG_DT_FACTOR,
        bwms_pkg::CFG_START_DT: begin
          if (cfg_index == bwms_pkg::CFG_BIN_COUNT) begin
            bin_count_nxt = cfg_data[bwms_pkg::BC_W-1:0];
          end
          if (cfg_index == bwms_pkg::CFG_DT_FACTOR) begin
            dt_factor_nxt = cfg_data[bwms_pkg::FAC_W-1:0];
          end
          if (cfg_index == bwms_pkg::CFG_START_DT) begin
            start_dt_nxt = cfg_data[bwms_pkg::START_W-1:0];
          end
          // reseed the store
          vld_nxt         = '0;
          cur_bin_nxt     = '0;
          total_time_nxt  = TW'(bwms_pkg::ten_times(start_dt_nxt));
          total_steps_nxt = SW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= bwms_pkg::BC_W'(8);
      dt_factor_r   <= bwms_pkg::FAC_W'(65536);
      start_dt_r    <= bwms_pkg::START_W'(65536);
      state_r       <= bwms_pkg::ST_IDLE;
      cur_bin_r     <= '0;
      total_time_r  <= TW'(bwms_pkg::ten_times(bwms_pkg::START_W'(65536)));
      total_steps_r <= SW'(1);
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bin_count_r   <= bin_count_nxt;
      dt_factor_r   <= dt_factor_nxt;
      start_dt_r    <= start_dt_nxt;
      state_r       <= state_nxt;
      cur_bin_r     <= cur_bin_nxt;
      total_time_r  <= total_time_nxt;
      total_steps_r <= total_steps_nxt;
      vld_r         <= vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r      <= span_nxt;
    dt_r        <= dt_nxt;
    new_time_r  <= new_time_nxt;
    new_steps_r <= new_steps_nxt;
    delta_r     <= delta_nxt;
    inc_r       <= inc_nxt;
    prod_r      <= prod_nxt;
    mplr_r      <= mplr_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    quo_r       <= quo_nxt;
    sat_r       <= sat_nxt;
    out_data_r  <= out_data_nxt;
  end

  // bin store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_time_mem[mem_wa]  <= mem_wtime;
      bin_steps_mem[mem_wa] <= mem_wsteps;
    end
    rd_time_r  <= bin_time_mem[rd_addr];
    rd_steps_r <= bin_steps_mem[rd_addr];
    rd_vld_r   <= vld_r[rd_addr];
    rd_bin_r   <= rd_addr;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cfg_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == bwms_pkg::CFG_BIN_COUNT ||
      cfg_index == bwms_pkg::CFG_DT_FACTOR || cfg_index == bwms_pkg::CFG_START_DT))
    |=> (total_steps_r == SW'(1)) && (cur_bin_r == '0) && (vld_r == '0))
    else $error("store not reseeded after a register write");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bins_used != '0) |-> (NW'(cur_bin_r) < bins_used))
    else $error("current bin outside the bins in use");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bwms_pkg::ST_EMIT))
    else $error("result word loaded outside the emit state");

  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwms_pkg::ST_MUL || state_r == bwms_pkg::ST_DIV) |-> !mem_we)
    else $error("bin store written while the mean is being formed");

endmodule
